// ===== rtl/ofs_pkg.sv =====
// ----------------------------------------------------------------------------
// Occupancy feedback scheduler package
// Shared constants, register indexes and the item types that pass between
// the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package ofs_pkg;

    localparam int NUM_PINS   = 8;
    localparam int NUM_BITS   = 8;
    localparam int MAP_W      = 3;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_DATA_W-1:0] PIN_MAP_RESET = 24'hFAC688;

    // Bit positions inside a feedback nibble item.
    localparam int BIT_D0     = 7;
    localparam int BIT_D1     = 6;
    localparam int BIT_D2     = 5;
    localparam int BIT_D3     = 4;
    localparam int BIT_NIBBLE = 3;

    localparam int MAX_RESULTS = 4;
    localparam int RES_CNT_W   = 3;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic KIND_RELAY  = 1'b0;
    localparam logic KIND_NIBBLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REVERSER = 2'd0,
        CFG_PIN_MAP  = 2'd1,
        CFG_TX_COUNT = 2'd2,
        CFG_BUS_ADDR = 2'd3
    } t_cfg_idx;

    // One classified feedback period, as handed from the front to the back.
    typedef struct packed {
        logic                relay_on;
        logic                relay_off;
        logic [NUM_BITS-1:0] want_on;
        logic [NUM_BITS-1:0] want_off;
        logic [1:0]          count;
        logic                send_en;
        logic                bus_active;
        logic                uart_busy;
    } t_cmd;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload;
        logic       last;
    } t_res;

    // Builds the data byte of a feedback nibble from its four bits.
    function automatic logic [7:0] f_nibble(input logic [3:0] bits, input logic hi);
        logic [7:0] b;
        b             = 8'd0;
        b[BIT_D0]     = bits[0];
        b[BIT_D1]     = bits[1];
        b[BIT_D2]     = bits[2];
        b[BIT_D3]     = bits[3];
        b[BIT_NIBBLE] = hi;
        return b;
    endfunction

endpackage

// ===== rtl/ofs_in_if.sv =====
// ----------------------------------------------------------------------------
// Feedback period input channel
// Valid/ready channel that carries one feedback period per item.
// ----------------------------------------------------------------------------
interface ofs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] occupied_pins;
    logic [7:0] free_pins;
    logic       uart_busy;
    logic       bus_active;
    logic       startup_phase;

    modport source (
        output valid, occupied_pins, free_pins, uart_busy, bus_active, startup_phase,
        input  ready
    );
    modport sink (
        input  valid, occupied_pins, free_pins, uart_busy, bus_active, startup_phase,
        output ready
    );
endinterface

// ===== rtl/ofs_out_if.sv =====
// ----------------------------------------------------------------------------
// Scheduler result channel
// Valid/ready channel that carries one relay command or feedback byte per item.
// ----------------------------------------------------------------------------
interface ofs_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] payload;
    logic       last;

    modport source (output valid, kind, payload, last, input ready);
    modport sink   (input valid, kind, payload, last, output ready);
endinterface

// ===== rtl/ofs_front.sv =====
// ----------------------------------------------------------------------------
// Scheduler front end
// Holds the configuration registers, accepts feedback periods and classifies
// each into relay requests and per-bit on/off wishes for the back end.
// ----------------------------------------------------------------------------
module ofs_front
    import ofs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ofs_in_if.sink                i_in,
    input  logic                  i_queue_full,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    logic                  r_reverser;
    logic [CFG_DATA_W-1:0] r_pin_map;
    logic [1:0]            r_tx_count;
    logic [7:0]            r_bus_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverser <= 1'b0;
            r_pin_map  <= PIN_MAP_RESET;
            r_tx_count <= 2'd1;
            r_bus_addr <= 8'd0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_REVERSER: r_reverser <= i_cfg_data[0];
                CFG_PIN_MAP:  r_pin_map  <= i_cfg_data;
                CFG_TX_COUNT: r_tx_count <= i_cfg_data[1:0];
                CFG_BUS_ADDR: r_bus_addr <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready = !i_queue_full;
    assign o_push     = i_in.valid && !i_queue_full;

    // A pin that is both occupied and free counts on both sides.
    always_comb begin
        logic [MAP_W-1:0] tgt;
        o_cmd          = '0;
        o_cmd.want_off = '1;
        for (int i = 0; i < NUM_PINS; i++) begin
            tgt = r_reverser ? r_pin_map[MAP_W*i +: MAP_W] : MAP_W'(i);
            if (i_in.occupied_pins[i]) begin
                o_cmd.want_on[tgt] = 1'b1;
            end
            if (!i_in.free_pins[i]) begin
                o_cmd.want_off[tgt] = 1'b0;
            end
        end
        o_cmd.relay_on   = r_reverser && (i_in.occupied_pins[2:1] != 2'b00);
        o_cmd.relay_off  = r_reverser && (i_in.occupied_pins[5:4] != 2'b00);
        o_cmd.count      = (r_tx_count == 2'd0) ? 2'd1 : r_tx_count;
        o_cmd.send_en    = (r_bus_addr != 8'd0) && !i_in.startup_phase;
        o_cmd.bus_active = i_in.bus_active;
        o_cmd.uart_busy  = i_in.uart_busy;
    end

endmodule

// ===== rtl/ofs_queue.sv =====
// ----------------------------------------------------------------------------
// Scheduler command queue
// Short FIFO of classified periods between the front end and the back end.
// ----------------------------------------------------------------------------
module ofs_queue
    import ofs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_cmd                       i_wdata,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic                       o_valid,
    output t_cmd                       o_rdata,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rd];
    assign o_count = r_cnt;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/ofs_back.sv =====
// ----------------------------------------------------------------------------
// Scheduler back end
// Owns the feedback state, applies one classified period per pop and drains
// its relay commands and nibble bytes one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module ofs_back
    import ofs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  t_cmd                 i_cmd,
    output logic                 o_pop,
    ofs_out_if.source            o_out,
    output logic [RES_CNT_W-1:0] o_res_cnt
);

    logic [NUM_BITS-1:0]      r_sent;
    logic [NUM_BITS-1:0]      r_pend;
    logic [NUM_BITS-1:0][1:0] r_sl;
    logic                     r_conn;
    t_res                     r_res [MAX_RESULTS];
    logic [RES_CNT_W-1:0]     r_cnt;

    logic [NUM_BITS-1:0]      n_sent;
    logic [NUM_BITS-1:0]      n_pend;
    logic [NUM_BITS-1:0][1:0] n_sl;
    logic                     n_conn;
    t_res                     n_res [MAX_RESULTS];
    logic [RES_CNT_W-1:0]     n_cnt;

    logic take;
    logic can_load;

    assign o_out.valid   = (r_cnt != '0);
    assign o_out.kind    = r_res[0].kind;
    assign o_out.payload = r_res[0].payload;
    assign o_out.last    = r_res[0].last;
    assign o_res_cnt     = r_cnt;

    assign take     = o_out.valid && o_out.ready;
    assign can_load = (r_cnt == '0) || ((r_cnt == RES_CNT_W'(1)) && take);
    assign o_pop    = i_cmd_valid && can_load;

    always_comb begin
        logic [NUM_BITS-1:0]      pend_w;
        logic [NUM_BITS-1:0][1:0] sl_w;
        logic                     due_lo;
        logic                     due_hi;
        logic                     send_lo;
        logic                     send_hi;
        t_res                     cand [MAX_RESULTS];
        logic [MAX_RESULTS-1:0]   cand_v;
        t_res                     list [MAX_RESULTS];
        logic [RES_CNT_W-1:0]     k;
        logic [RES_CNT_W-1:0]     k_last;

        pend_w = r_pend;
        sl_w   = r_sl;
        for (int i = 0; i < NUM_BITS; i++) begin
            if (i_cmd.want_on[i] && !r_sent[i]) begin
                pend_w[i] = 1'b1;
                sl_w[i]   = i_cmd.count;
            end
            if (i_cmd.want_off[i] && r_sent[i]) begin
                pend_w[i] = 1'b0;
                sl_w[i]   = i_cmd.count;
            end
        end
        due_lo = (sl_w[0] != 2'd0) || (sl_w[1] != 2'd0) || (sl_w[2] != 2'd0)
              || (sl_w[3] != 2'd0);
        due_hi = (sl_w[4] != 2'd0) || (sl_w[5] != 2'd0) || (sl_w[6] != 2'd0)
              || (sl_w[7] != 2'd0);

        // Registration sends both nibbles once; afterwards one nibble per
        // idle UART period, low nibble first.
        send_lo = 1'b0;
        send_hi = 1'b0;
        n_conn  = r_conn;
        if (i_cmd.send_en) begin
            if (!r_conn) begin
                if (i_cmd.bus_active) begin
                    send_lo = 1'b1;
                    send_hi = 1'b1;
                    n_conn  = 1'b1;
                end
            end else if (!i_cmd.uart_busy) begin
                if (due_lo) begin
                    send_lo = 1'b1;
                end else if (due_hi) begin
                    send_hi = 1'b1;
                end
            end
        end

        n_sent = r_sent;
        n_pend = pend_w;
        n_sl   = sl_w;
        for (int i = 0; i < NUM_BITS; i++) begin
            if ((i < 4) ? send_lo : send_hi) begin
                n_sent[i] = pend_w[i];
                if (sl_w[i] != 2'd0) begin
                    n_sl[i] = sl_w[i] - 2'd1;
                end
            end
        end

        cand[0] = '{kind: KIND_RELAY, payload: 8'd1, last: 1'b0};
        cand[1] = '{kind: KIND_RELAY, payload: 8'd0, last: 1'b0};
        cand[2] = '{kind: KIND_NIBBLE,
                    payload: send_lo ? f_nibble(pend_w[3:0], 1'b0)
                                     : f_nibble(pend_w[7:4], 1'b1),
                    last: 1'b0};
        cand[3] = '{kind: KIND_NIBBLE, payload: f_nibble(pend_w[7:4], 1'b1), last: 1'b0};
        cand_v  = {send_lo && send_hi, send_lo || send_hi, i_cmd.relay_off, i_cmd.relay_on};

        for (int j = 0; j < MAX_RESULTS; j++) begin
            list[j] = cand[j];
        end
        k = '0;
        for (int j = 0; j < MAX_RESULTS; j++) begin
            if (cand_v[j]) begin
                list[k[1:0]] = cand[j];
                k            = k + 1'b1;
            end
        end
        k_last = k - 1'b1;
        if (k != '0) begin
            list[k_last[1:0]].last = 1'b1;
        end

        // The list holds still while the head result waits to be taken.
        n_res = r_res;
        n_cnt = r_cnt;
        if (o_pop) begin
            n_res = list;
            n_cnt = k;
        end else if (take) begin
            for (int j = 0; j < MAX_RESULTS - 1; j++) begin
                n_res[j] = r_res[j + 1];
            end
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent <= '0;
            r_pend <= '0;
            r_sl   <= '0;
            r_conn <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (o_pop) begin
                r_sent <= n_sent;
                r_pend <= n_pend;
                r_sl   <= n_sl;
                r_conn <= n_conn;
            end
        end
    end

endmodule

// ===== rtl/occupancy_feedback_scheduler.sv =====
// ----------------------------------------------------------------------------
// Occupancy feedback scheduler
// With the queue and result list empty, an accepted item is written into the
// queue, popped into the registered result list, and its first result is then
// offered; an item's results leave the list one at a time.
// Throughput: while the result channel is ready, one item per cycle if each item
// causes at most one result; otherwise set by the list, one result per cycle.
// Reset: synchronous, active low; registers take their defaults, the
// feedback state and connection flag clear, and the queue empties.
// ----------------------------------------------------------------------------
module occupancy_feedback_scheduler
    import ofs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ofs_in_if.sink                i_in,
    ofs_out_if.source             o_out
);

    // The front end turns each accepted period into a command: the two relay
    // requests of reverser mode, and for every feedback bit whether it should
    // be on (some mapped pin occupied) and whether it may go off (all mapped
    // pins free). It needs no state of its own beyond the configuration, so
    // it keeps accepting items as long as the queue has room.
    logic                           push;
    logic                           q_full;
    logic                           q_valid;
    logic                           pop;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
    logic [RES_CNT_W-1:0]           res_cnt;
    t_cmd                           cmd_in;
    t_cmd                           cmd_out;

    ofs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in         (i_in),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_cmd        (cmd_in)
    );

    // The queue decouples classification from execution, so a stalled
    // result channel does not stop input items at once.
    ofs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (cmd_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rdata (cmd_out),
        .o_count (q_count)
    );

    // The back end applies one command per pop: it updates pending values
    // and retry counters, decides on registration or a nibble send, and
    // loads the item's results into a small result list. A new command is
    // popped while the last result of the previous one is being taken.
    ofs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (cmd_out),
        .o_pop       (pop),
        .o_out       (o_out),
        .o_res_cnt   (res_cnt)
    );

    // The queue never holds more commands than it has entries.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= QUEUE_DEPTH)
        else $error("command queue count exceeds its depth");

    // Input is held off only when the queue is full.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> q_full)
        else $error("input stalled while the queue has room");

    // The result list never holds more than four results.
    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_cnt <= RES_CNT_W'(MAX_RESULTS))
        else $error("result list overflow");

    // The final result waiting in the list always closes its item.
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && res_cnt == RES_CNT_W'(1)) |-> o_out.last)
        else $error("final result of an item lacks its last mark");

    // A result is offered exactly when the list is not empty.
    a_valid_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid == (res_cnt != '0))
        else $error("result valid disagrees with the result count");

endmodule
